FILE: hw/rtl/ftps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftps_pkg
// Shared types and constants of the frame time pacing smoother.
// ----------------------------------------------------------------------------
package ftps_pkg;

  localparam int WindowDepth = 9;
  localparam int MedianRank  = WindowDepth / 2;
  localparam int IdxW        = $clog2(WindowDepth);

  localparam logic ActStart = 1'b0;
  localparam logic ActTick  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [63:0] timestamp_now;
  } in_t;

  typedef struct packed {
    logic [63:0] paced_delta;
    logic [63:0] raw_delta;
    logic [63:0] median_average;
  } out_t;

  typedef enum logic {
    OpDiv = 1'b0,
    OpMul = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic        start;
    arith_op_t   op;
    logic [63:0] a;
    logic [63:0] b;
  } arith_req_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ftps_arith.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftps_arith
// Shared 64-bit serial unit: restoring divide a / b or product a * b modulo
// 2^64, two bits per cycle.
// ----------------------------------------------------------------------------
module ftps_arith (
  input  wire               clk,
  input  wire               rst,
  input  wire ftps_pkg::arith_req_t req,
  output logic              done,
  output logic [63:0]       result
);

  logic              busy;
  logic [4:0]        cnt;
  ftps_pkg::arith_op_t op;
  logic [63:0]       rem;   // remainder, or accumulator for a product
  logic [63:0]       quo;   // dividend and quotient, or multiplier
  logic [63:0]       opb;   // divisor, or shifted multiplicand

  logic [63:0] rem_next, quo_next, opb_next;
  logic [64:0] t0, t1;
  logic        ge0, ge1;
  logic [63:0] r0;

  always_comb begin
    t0 = {rem, quo[63]};
    ge0 = t0 >= {1'b0, opb};
    r0 = ge0 ? 64'(t0 - {1'b0, opb}) : t0[63:0];
    t1 = {r0, quo[62]};
    ge1 = t1 >= {1'b0, opb};
    if (op == ftps_pkg::OpDiv) begin
      rem_next = ge1 ? 64'(t1 - {1'b0, opb}) : t1[63:0];
      quo_next = {quo[61:0], ge0, ge1};
      opb_next = opb;
    end else begin
      rem_next = rem + (quo[0] ? opb : 64'd0) + (quo[1] ? {opb[62:0], 1'b0} : 64'd0);
      quo_next = {2'b00, quo[63:2]};
      opb_next = {opb[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        op   <= req.op;
        rem  <= '0;
        if (req.op == ftps_pkg::OpDiv) begin
          quo <= req.a;
          opb <= req.b;
        end else begin
          quo <= req.b;
          opb <= req.a;
        end
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo_next;
        opb <= opb_next;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = (op == ftps_pkg::OpDiv) ? quo : rem;

endmodule
`default_nettype wire

FILE: hw/rtl/frame_time_pacing_smoother_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_time_pacing_smoother_unit
// Frame time pacing smoother: raw, median-averaged and paced frame deltas.
// ----------------------------------------------------------------------------
// Usage:
//   in_data carries action and timestamp_now; a request is taken when in_valid
//   is high and in_stall is low. A start request loads both clocks and gives
//   no result. A tick request gives one result on out_data.
//   in_stall is high while a tick is being worked on.
// Tick processing:
//   A tick sweeps the 9-entry delta window with one comparator to find the
//   median, one compare per cycle. With a nonzero average it then runs four
//   jobs in turn on the shared serial divide/multiply unit (frame count,
//   product, pacing blend, window value). When the window still holds a zero,
//   the sweep ends after the first candidate and the jobs are skipped.
// Reset:
//   rst (synchronous) clears both clocks, the running average, the window
//   position and the window valid bits, so every window entry reads zero.
// Stall:
//   A result waits in the output register while out_stall is high; a new
//   request may be taken meanwhile, and its result waits until the slot frees.
// ----------------------------------------------------------------------------
module frame_time_pacing_smoother_unit (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire ftps_pkg::in_t in_data,
  output logic             out_valid,
  input  wire              out_stall,
  output ftps_pkg::out_t   out_data
);

  localparam int D = ftps_pkg::WindowDepth;
  localparam int W = ftps_pkg::IdxW;
  localparam logic [W-1:0] LastIdx = W'(D - 1);
  localparam logic [W-1:0] Rank    = W'(ftps_pkg::MedianRank);

  typedef enum logic [2:0] {
    IDLE, MED, AVG, DIVN, MUL, DIV6, DIVR, FIN
  } state_t;

  state_t      state;
  logic [63:0] last_time, smooth_clock, median_running;
  logic [63:0] raw, paced, avg, med, cnt_n, pushv;
  logic [W-1:0] pos, ci, cj, ci_d, cj_d, cnt;
  logic        pv, zf;

  logic [63:0] mem [D];
  logic [D-1:0] valid;
  logic [63:0] cand_q, wj_q;

  ftps_pkg::arith_req_t areq;
  logic        adone;
  logic [63:0] ares;

  ftps_arith u_arith (
    .clk(clk), .rst(rst), .req(areq), .done(adone), .result(ares)
  );

  logic        accept, slot_free, lt, zf_new;
  logic [W-1:0] cnt_new;
  logic [63:0] mr_new, n_fix;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    lt      = (wj_q < cand_q) || ((wj_q == cand_q) && (cj_d < ci_d));
    cnt_new = cnt + W'(lt);
    zf_new  = zf || ((ci_d == '0) && (wj_q == 64'd0));
    if (median_running == 64'd0) begin
      mr_new = med;
    end else begin
      mr_new = (med + ((median_running << 5) - median_running)) >> 5;
    end
    n_fix = (ares == 64'd0) ? 64'd1 : ares;
  end

  // Window storage: two registered read ports, one write port.
  always_ff @(posedge clk) begin
    cand_q <= valid[ci] ? mem[ci] : 64'd0;
    wj_q   <= valid[cj] ? mem[cj] : 64'd0;
    if (state == FIN && slot_free) begin
      mem[pos] <= pushv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      last_time      <= '0;
      smooth_clock   <= '0;
      median_running <= '0;
      pos            <= '0;
      valid          <= '0;
      out_valid      <= 1'b0;
      areq.start     <= 1'b0;
      ci <= '0; cj <= '0; ci_d <= '0; cj_d <= '0; cnt <= '0; pv <= 1'b0; zf <= 1'b0;
    end else begin
      areq.start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            if (in_data.action == ftps_pkg::ActStart) begin
              last_time    <= in_data.timestamp_now;
              smooth_clock <= in_data.timestamp_now;
            end else begin
              raw       <= in_data.timestamp_now - last_time;
              last_time <= in_data.timestamp_now;
              paced     <= (in_data.timestamp_now > smooth_clock)
                           ? in_data.timestamp_now - smooth_clock : 64'd0;
              ci <= '0; cj <= '0; cnt <= '0; pv <= 1'b0; zf <= 1'b0;
              state <= MED;
            end
          end
        end
        MED: begin
          // Reads are registered, so compares use the delayed indices. A
          // candidate is the median when exactly Rank entries sort ahead of
          // it, ties broken by position.
          ci_d <= ci;
          cj_d <= cj;
          pv   <= 1'b1;
          if (cj == LastIdx) begin
            cj <= '0;
            if (ci != LastIdx) begin
              ci <= ci + W'(1);
            end
          end else begin
            cj <= cj + W'(1);
          end
          if (pv) begin
            zf <= zf_new;
            if (cj_d == LastIdx) begin
              cnt <= '0;
              if ((ci_d == '0) && zf_new) begin
                avg   <= 64'd0;
                pushv <= raw;
                state <= FIN;
              end else if (cnt_new == Rank) begin
                med   <= cand_q;
                state <= AVG;
              end
            end else begin
              cnt <= cnt_new;
            end
          end
        end
        AVG: begin
          median_running <= mr_new;
          avg            <= mr_new;
          if (mr_new == 64'd0) begin
            pushv <= raw;
            state <= FIN;
          end else begin
            areq.start <= 1'b1;
            areq.op    <= ftps_pkg::OpDiv;
            areq.a     <= paced + (mr_new >> 1);
            areq.b     <= mr_new;
            state      <= DIVN;
          end
        end
        DIVN: begin
          if (adone) begin
            cnt_n      <= n_fix;
            areq.start <= 1'b1;
            areq.op    <= ftps_pkg::OpMul;
            areq.a     <= avg;
            areq.b     <= n_fix;
            state      <= MUL;
          end
        end
        MUL: begin
          if (adone) begin
            areq.start <= 1'b1;
            areq.op    <= ftps_pkg::OpDiv;
            areq.a     <= paced + (ares << 2) + ares;
            areq.b     <= 64'd6;
            state      <= DIV6;
          end
        end
        DIV6: begin
          if (adone) begin
            paced      <= ares;
            areq.start <= 1'b1;
            areq.op    <= ftps_pkg::OpDiv;
            areq.a     <= raw;
            areq.b     <= cnt_n;
            state      <= DIVR;
          end
        end
        DIVR: begin
          if (adone) begin
            pushv <= ares;
            state <= FIN;
          end
        end
        FIN: begin
          if (slot_free) begin
            valid[pos]   <= 1'b1;
            pos          <= (pos == LastIdx) ? '0 : pos + W'(1);
            smooth_clock <= smooth_clock + paced;
            out_valid    <= 1'b1;
            out_data.paced_delta    <= paced;
            out_data.raw_delta      <= raw;
            out_data.median_average <= avg;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= LastIdx)
    else $error("window position out of range");
  a_tick_sweep: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.action == ftps_pkg::ActTick |=> state == MED)
    else $error("tick did not start the median sweep");
  a_done_state: assert property (@(posedge clk) disable iff (rst)
    adone |-> (state == DIVN || state == MUL || state == DIV6 || state == DIVR))
    else $error("arithmetic result outside a waiting state");
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    state == FIN && !out_valid |=> state == IDLE && out_valid)
    else $error("result not delivered from a free slot");

endmodule
`default_nettype wire

FILE: tb/frame_time_pacing_smoother_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_time_pacing_smoother_unit_test
// Drives start and tick requests into the pacing smoother with random gaps and
// output stalls, predicts each tick's paced, raw and averaged deltas, and
// compares every result against the oldest prediction.
// ----------------------------------------------------------------------------
module frame_time_pacing_smoother_unit_test;

  localparam int WatchdogLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ftps_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ftps_pkg::out_t out_data;

  always #6 clk = ~clk;

  frame_time_pacing_smoother_unit DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  // Predictor state.
  logic [63:0] prev_frame_time, paced_clock, median_avg_state;
  logic [63:0] deltas [ftps_pkg::WindowDepth];
  int unsigned slot;

  ftps_pkg::in_t pending_reqs[$];
  ftps_pkg::out_t expected_deltas[$];
  int errors = 0;
  int idle_pct = 23;
  int hold_left = 0;
  bit drain_wait = 1'b0;
  int quiet_cycles = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic void predictor_clear();
    prev_frame_time = '0;
    paced_clock = '0;
    median_avg_state = '0;
    slot = 0;
    foreach (deltas[i]) deltas[i] = '0;
  endfunction

  function automatic void predict_request(input ftps_pkg::in_t req);
    logic [63:0] raw, paced, avg, m, n, t;
    logic [63:0] srt [ftps_pkg::WindowDepth];
    bit has_zero;
    if (req.action == ftps_pkg::ActStart) begin
      prev_frame_time = req.timestamp_now;
      paced_clock = req.timestamp_now;
      return;
    end
    raw = req.timestamp_now - prev_frame_time;
    prev_frame_time = req.timestamp_now;
    paced = (prev_frame_time > paced_clock) ? prev_frame_time - paced_clock : '0;
    has_zero = 1'b0;
    foreach (deltas[i]) begin
      srt[i] = deltas[i];
      if (deltas[i] == 0) has_zero = 1'b1;
    end
    avg = '0;
    if (!has_zero) begin
      for (int i = 1; i < ftps_pkg::WindowDepth; i++)
        for (int j = i; j > 0 && srt[j-1] > srt[j]; j--) begin
          t = srt[j]; srt[j] = srt[j-1]; srt[j-1] = t;
        end
      m = srt[ftps_pkg::MedianRank];
      if (median_avg_state == 0) median_avg_state = m;
      else median_avg_state = (m + median_avg_state * 64'd31) / 64'd32;
      avg = median_avg_state;
    end
    if (avg != 0) begin
      n = (paced + avg / 2) / avg;
      if (n == 0) n = 1;
      paced = (paced + 64'd5 * avg * n) / 64'd6;
      deltas[slot] = raw / n;
    end else begin
      deltas[slot] = raw;
    end
    slot = (slot + 1) % ftps_pkg::WindowDepth;
    paced_clock = paced_clock + paced;
    expected_deltas.push_back('{paced_delta: paced, raw_delta: raw,
                                median_average: avg});
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Driver: a request stays put while stalled. The receiver's long hold-off
  // is counted down here.
  always @(negedge clk) begin
    if (!rst) begin
      if (!(in_valid && in_stall)) begin
        if (pending_reqs.size() != 0 && !(drain_wait && expected_deltas.size() != 0)
            && $urandom_range(99) >= idle_pct) begin
          in_data <= pending_reqs[0];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < idle_pct);
      if (hold_left != 0) hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_request(in_data);
        void'(pending_reqs.pop_front());
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_deltas.size() == 0) begin
          report_mismatch("unexpected result", out_data.paced_delta, '0);
        end else begin
          ftps_pkg::out_t want;
          want = expected_deltas.pop_front();
          if (out_data.paced_delta !== want.paced_delta)
            report_mismatch("paced_delta", out_data.paced_delta, want.paced_delta);
          if (out_data.raw_delta !== want.raw_delta)
            report_mismatch("raw_delta", out_data.raw_delta, want.raw_delta);
          if (out_data.median_average !== want.median_average)
            report_mismatch("median_average", out_data.median_average,
                            want.median_average);
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles > WatchdogLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic add_req(input logic act, input logic [63:0] ts);
    pending_reqs.push_back('{action: act, timestamp_now: ts});
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_deltas.size() != 0)
      @(posedge clk);
  endtask

  // A frame sequence: start, then ticks with jittered period.
  task automatic add_frames(input int count, input logic [63:0] period,
                            input int jitter);
    logic [63:0] ts;
    ts = rand64();
    add_req(ftps_pkg::ActStart, ts);
    for (int i = 0; i < count; i++) begin
      ts = ts + period + $urandom_range(jitter) - jitter / 2;
      if ($urandom_range(19) == 0) ts = ts + period * $urandom_range(3, 1);
      add_req(ftps_pkg::ActTick, ts);
    end
  endtask

  initial begin
    predictor_clear();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, wraps, start, zero deltas.
    add_req(ftps_pkg::ActTick, 64'd0);
    add_req(ftps_pkg::ActTick, '1);
    add_req(ftps_pkg::ActTick, 64'd5);
    add_req(ftps_pkg::ActStart, '1);
    add_req(ftps_pkg::ActTick, 64'd3);
    add_req(ftps_pkg::ActStart, 64'd100);
    for (int i = 1; i <= 12; i++) add_req(ftps_pkg::ActTick, 64'd100 + i * 64'd16_666_667);
    add_req(ftps_pkg::ActTick, 64'h8000_0000_0000_0000);
    add_req(ftps_pkg::ActTick, 64'h0000_0000_0000_0001);
    add_req(ftps_pkg::ActStart, 64'h5555_5555_5555_5555);
    add_req(ftps_pkg::ActTick, 64'hAAAA_AAAA_AAAA_AAAA);
    add_req(ftps_pkg::ActTick, 64'hAAAA_AAAA_AAAA_AAAA);
    wait_drained();

    // Receiver holds off while the sender keeps offering.
    hold_left = 1500;
    add_frames(6, 64'd16_666_667, 2000);
    wait (hold_left == 0);
    wait_drained();

    // Sender pauses until every result has come.
    drain_wait = 1'b1;
    add_frames(12, 64'd8_333_333, 500);
    wait_drained();
    drain_wait = 1'b0;

    // No idling stretch.
    idle_pct = 0;
    add_frames(150, 64'd16_666_667, 200000);
    wait_drained();
    idle_pct = 23;

    // Random: mostly sequences, some noise.
    begin
      int total;
      total = 0;
      while (total < 1800) begin
        int c;
        c = $urandom_range(60, 10);
        case ($urandom_range(5))
          0: begin
            for (int i = 0; i < c; i++) add_req(1'($urandom_range(1)), rand64());
          end
          1: add_frames(c, 64'd1 + $urandom_range(50), 20);
          2: add_frames(c, rand64(), 1000);
          default: add_frames(c, 64'($urandom_range(40_000_000, 1_000_000)), 300000);
        endcase
        total += c;
      end
    end
    wait_drained();
    repeat (300) @(posedge clk);

    if (errors == 0 && expected_deltas.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
